// ----- rtl/core/bidef_pkg.sv -----
package bidef_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int DEPTH_MAX_DEF   = 255;
    localparam int SPAN_BITS       = 32;
    localparam int STATUS_BITS     = 3;
    localparam int OUT_TDATA_BITS  = 72;

    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [2:0] KEY_LEN  = 3'd6;

    typedef enum logic [2:0] {
        MODE_HUNT = 3'd0,
        MODE_SCAN = 3'd1,
        MODE_INT  = 3'd2,
        MODE_LEN  = 3'd3,
        MODE_SKIP = 3'd4,
        MODE_DONE = 3'd5
    } mode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_FOUND   = 3'd0,
        ST_NOKEY   = 3'd1,
        ST_ILLEGAL = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_OVER    = 3'd4
    } status_t;

    typedef struct packed {
        logic                 emit;
        status_t              status;
        logic [SPAN_BITS-1:0] span_start;
        logic [SPAN_BITS-1:0] span_end;
    } result_t;

    // characters of the key 4:info
    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h34;
            3'd1:    c = 8'h3a;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6e;
            3'd4:    c = 8'h66;
            3'd5:    c = 8'h6f;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/bencode_info_dict_extent_finder_core.sv -----
// a beat's result is registered in the input register, then in the output register, before it is presented
// throughput: one byte per cycle while no result beat waits, as the token and length update is combinational
// a waiting result beat holds the scan; one more byte fits in the input register
// reset: rst_n asynchronous active low, clears the scan state and both stages
// after every last beat the scan rearms to hunting for the key at offset zero
module bencode_info_dict_extent_finder_core #(
    parameter int OFFSET_BITS = bidef_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_MAX   = bidef_pkg::DEPTH_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // data_byte
    input  logic                                s_axis_tlast,  // last_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bidef_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata  // status, span_start, span_end
);
    import bidef_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           in_data_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [SPAN_BITS-1:0] out_start_reg;
    logic [SPAN_BITS-1:0] out_end_reg;
    logic                 advance;
    logic                 step;
    result_t              res;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    bidef_scanner #(
        .OFFSET_BITS (OFFSET_BITS),
        .DEPTH_MAX   (DEPTH_MAX)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res.emit;
    end

    always_ff @(posedge clk)
    begin
        if (res.emit)
        begin
            out_status_reg <= res.status;
            out_start_reg  <= res.span_start;
            out_end_reg    <= res.span_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_BITS - STATUS_BITS - 2*SPAN_BITS)'(0),
                            out_end_reg, out_start_reg, out_status_reg};

    a_emit_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit |-> step)
        else $error("result without an input beat");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !step)
        else $error("pending result overwritten");

    a_found_span: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit && res.status != ST_FOUND |-> res.span_start == '0 && res.span_end == '0)
        else $error("span set on error result");

endmodule

// ----- rtl/core/bidef_scanner.sv -----
module bidef_scanner #(
    parameter int OFFSET_BITS = bidef_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_MAX   = bidef_pkg::DEPTH_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output bidef_pkg::result_t res
);
    import bidef_pkg::*;

    localparam int DW = (DEPTH_MAX < 1) ? 1 : $clog2(DEPTH_MAX + 1);
    localparam int OB = OFFSET_BITS;

    mode_t           mode_reg, mode_next, mode_proc;
    logic [2:0]      key_reg, key_next, key_proc;
    logic [OB-1:0]   offset_reg, offset_next;
    logic [OB-1:0]   vstart_reg, vstart_next, vstart_proc;
    logic [DW-1:0]   depth_reg, depth_next, depth_proc;
    logic [OB-1:0]   skip_reg, skip_next, skip_proc;

    logic            is_digit, is_open, is_close, is_int;
    logic [3:0]      digit;
    logic            key_match, key_done, depth_full, depth_zero, depth_one;
    logic [OB+3:0]   len_wide;
    logic            len_ovf;
    logic [OB-1:0]   skip_dec;
    logic            emit_byte;
    status_t         status_byte;
    logic [OB+31:0]  start_ext, end_ext;

    assign is_digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign is_open    = (data_byte == CH_D) || (data_byte == CH_L);
    assign is_close   = (data_byte == CH_E);
    assign is_int     = (data_byte == CH_I);
    assign digit      = data_byte[3:0];

    assign key_match  = (key_reg < KEY_LEN) && (data_byte == key_char(key_reg));
    assign key_proc   = key_match ? key_reg + 3'd1 : ((data_byte == CH_FOUR) ? 3'd1 : 3'd0);
    assign key_done   = (key_proc == KEY_LEN);

    assign depth_full = (depth_reg >= DW'(DEPTH_MAX));
    assign depth_zero = (depth_reg == '0);
    assign depth_one  = (depth_reg == DW'(1));

    // skip * 10 + digit, overflow when it leaves the offset range
    assign len_wide   = {1'b0, skip_reg, 3'b000} + {3'b000, skip_reg, 1'b0} + (OB+4)'(digit);
    assign len_ovf    = (len_wide[OB+3:OB] != 4'd0);
    assign skip_dec   = (skip_reg != '0) ? skip_reg - OB'(1) : skip_reg;

    // next state
    always_comb
    begin
        mode_proc = mode_reg;
        unique case (mode_reg)
            MODE_HUNT:
            begin
                if (key_done)
                    mode_proc = MODE_SCAN;
            end
            MODE_SCAN:
            begin
                priority if (is_open)
                begin
                    if (depth_full)
                        mode_proc = MODE_DONE;
                end
                else if (is_int)
                    mode_proc = MODE_INT;
                else if (is_digit)
                    mode_proc = MODE_LEN;
                else if (is_close)
                begin
                    if (depth_zero || depth_one)
                        mode_proc = MODE_DONE;
                end
                else
                    mode_proc = MODE_DONE;
            end
            MODE_INT:
            begin
                if (is_close)
                    mode_proc = MODE_SCAN;
            end
            MODE_LEN:
            begin
                if (is_digit)
                begin
                    if (len_ovf)
                        mode_proc = MODE_DONE;
                end
                else
                    mode_proc = (skip_reg == '0) ? MODE_SCAN : MODE_SKIP;
            end
            MODE_SKIP:
            begin
                if (skip_dec == '0)
                    mode_proc = MODE_SCAN;
            end
            MODE_DONE:
                mode_proc = MODE_DONE;
            default:
                mode_proc = MODE_HUNT;
        endcase

        mode_next = mode_reg;
        if (step)
            mode_next = last_byte ? MODE_HUNT : mode_proc;
    end

    // outputs and datapath
    always_comb
    begin
        emit_byte   = 1'b0;
        status_byte = ST_FOUND;
        key_next    = key_reg;
        vstart_proc = vstart_reg;
        depth_proc  = depth_reg;
        skip_proc   = skip_reg;

        unique case (mode_reg)
            MODE_HUNT:
            begin
                key_next = key_proc;
                if (key_done)
                begin
                    vstart_proc = offset_reg + OB'(1);
                    depth_proc  = '0;
                end
            end
            MODE_SCAN:
            begin
                priority if (is_open)
                begin
                    if (depth_full)
                    begin
                        emit_byte   = 1'b1;
                        status_byte = ST_OVER;
                    end
                    else
                        depth_proc = depth_reg + DW'(1);
                end
                else if (is_int)
                    depth_proc = depth_reg;
                else if (is_digit)
                    skip_proc = OB'(digit);
                else if (is_close)
                begin
                    if (depth_zero)
                    begin
                        emit_byte   = 1'b1;
                        status_byte = ST_ILLEGAL;
                    end
                    else
                    begin
                        depth_proc = depth_reg - DW'(1);
                        if (depth_one)
                        begin
                            emit_byte   = 1'b1;
                            status_byte = ST_FOUND;
                        end
                    end
                end
                else
                begin
                    emit_byte   = 1'b1;
                    status_byte = ST_ILLEGAL;
                end
            end
            MODE_LEN:
            begin
                if (is_digit)
                begin
                    if (len_ovf)
                    begin
                        emit_byte   = 1'b1;
                        status_byte = ST_OVER;
                    end
                    else
                        skip_proc = len_wide[OB-1:0];
                end
            end
            MODE_SKIP:
                skip_proc = skip_dec;
            default:
                emit_byte = 1'b0;
        endcase

        res.emit   = step && (emit_byte || (last_byte && (mode_proc != MODE_DONE)));
        res.status = emit_byte ? status_byte
                   : ((mode_proc == MODE_HUNT) ? ST_NOKEY : ST_TRUNC);
        start_ext  = {32'b0, vstart_reg};
        end_ext    = {32'b0, offset_reg};
        if (emit_byte && (status_byte == ST_FOUND))
        begin
            res.span_start = start_ext[SPAN_BITS-1:0];
            res.span_end   = end_ext[SPAN_BITS-1:0];
        end
        else
        begin
            res.span_start = '0;
            res.span_end   = '0;
        end

        vstart_next = vstart_reg;
        depth_next  = depth_reg;
        skip_next   = skip_reg;
        offset_next = offset_reg;
        if (step)
        begin
            if (last_byte)
            begin
                key_next    = '0;
                vstart_next = '0;
                depth_next  = '0;
                skip_next   = '0;
                offset_next = '0;
            end
            else
            begin
                vstart_next = vstart_proc;
                depth_next  = depth_proc;
                skip_next   = skip_proc;
                offset_next = offset_reg + OB'(1);
            end
        end
        else
            key_next = key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HUNT;
            key_reg    <= '0;
            offset_reg <= '0;
            vstart_reg <= '0;
            depth_reg  <= '0;
            skip_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            key_reg    <= key_next;
            offset_reg <= offset_next;
            vstart_reg <= vstart_next;
            depth_reg  <= depth_next;
            skip_reg   <= skip_next;
        end
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(DEPTH_MAX))
        else $error("nesting depth above limit");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> mode_reg == MODE_HUNT && offset_reg == '0 && key_reg == '0)
        else $error("no rearm after last beat");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit |-> mode_reg != MODE_DONE)
        else $error("second result for one file");

    a_key_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HUNT |-> key_reg < KEY_LEN)
        else $error("key progress past key length while hunting");

endmodule

// ----- bench/tb_bencode_info_dict_extent_finder_core.sv -----
module tb_bencode_info_dict_extent_finder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bidef_pkg::*;

    localparam logic [47:0] INFO_KEY = "4:info";
    localparam logic [63:0] OFF_MASK = (64'd1 << OFFSET_BITS_DEF) - 64'd1;
    localparam logic [7:0]  CH_COLON = 8'h3a;
    localparam logic [7:0]  CH_MINUS = 8'h2d;
    localparam int          DIR_ROWS = 18;
    localparam int          PHASE_BYTES = 115;

    typedef struct packed {
        status_t              status;
        logic [SPAN_BITS-1:0] start_off;
        logic [SPAN_BITS-1:0] end_off;
    } span_rec_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata;
    logic                      s_axis_tlast;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b1;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    bencode_info_dict_extent_finder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // scan state of the predictor
    logic [2:0]  key_pos;
    mode_t       scan_mode;
    logic [63:0] byte_off;
    logic [63:0] val_start;
    logic [7:0]  nest;
    logic [63:0] skip_len;
    bit          span_ready;
    span_rec_t   span_out;

    span_rec_t   span_q[$];
    logic [7:0]  file_q[$];
    bit          use_typed;
    span_rec_t   typed_span;

    int err_cnt = 0;
    int bytes_sent = 0;
    int files_sent = 0;
    int found_seen = 0;
    int fail_seen = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    // directed files; typed rows carry their span, the rest go through the predictor
    string dir_text [DIR_ROWS] = '{
        "4:infode",
        "\377\2004:infode",
        "xyz",
        "4",
        "4:infoe",
        "4:info?",
        "4:info",
        "4:info5:ab",
        "4:infod4294967295",
        "4:infod4294967296",
        "4:infod99999999999e",
        "4:infoi42e3:abcde",
        "4:infod3xabce",
        "4:infod0:e",
        "44:infole",
        "4:inf4:infoli-7el1:eeee",
        "4:infodexyz",
        "4:infod4:infoi9e"
    };
    bit dir_typed [DIR_ROWS] = '{
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0
    };
    span_rec_t dir_exp [DIR_ROWS] = '{
        '{ST_FOUND,   32'd6, 32'd7},
        '{ST_FOUND,   32'd8, 32'd9},
        '{ST_NOKEY,   32'd0, 32'd0},
        '{ST_NOKEY,   32'd0, 32'd0},
        '{ST_ILLEGAL, 32'd0, 32'd0},
        '{ST_ILLEGAL, 32'd0, 32'd0},
        '{ST_TRUNC,   32'd0, 32'd0},
        '{ST_TRUNC,   32'd0, 32'd0},
        '{ST_TRUNC,   32'd0, 32'd0},
        '{ST_OVER,    32'd0, 32'd0},
        '{ST_OVER,    32'd0, 32'd0},
        '{ST_FOUND,   32'd0, 32'd0},
        '{ST_FOUND,   32'd0, 32'd0},
        '{ST_FOUND,   32'd0, 32'd0},
        '{ST_FOUND,   32'd0, 32'd0},
        '{ST_FOUND,   32'd0, 32'd0},
        '{ST_FOUND,   32'd0, 32'd0},
        '{ST_FOUND,   32'd0, 32'd0}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic clear_scan();
        key_pos   = 3'd0;
        scan_mode = MODE_HUNT;
        byte_off  = '0;
        val_start = '0;
        nest      = '0;
        skip_len  = '0;
    endtask

    task automatic close_scan(input status_t st, input logic [63:0] s, input logic [63:0] e);
        span_ready = 1'b1;
        span_out   = '{st, s[SPAN_BITS-1:0], e[SPAN_BITS-1:0]};
        scan_mode  = MODE_DONE;
    endtask

    // one byte through the token walker
    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic [63:0] digit;
        span_ready = 1'b0;
        digit = 64'(b - CH_ZERO);
        case (scan_mode)
            MODE_HUNT:
            begin
                if (key_pos < KEY_LEN && b == INFO_KEY[8 * (5 - key_pos) +: 8])
                    key_pos = key_pos + 3'd1;
                else
                    key_pos = (b == CH_FOUR) ? 3'd1 : 3'd0;
                if (key_pos == KEY_LEN)
                begin
                    val_start = (byte_off + 64'd1) & OFF_MASK;
                    nest      = '0;
                    scan_mode = MODE_SCAN;
                end
            end
            MODE_SCAN:
            begin
                if (b == CH_D || b == CH_L)
                begin
                    if (nest >= DEPTH_MAX_DEF)
                        close_scan(ST_OVER, 64'd0, 64'd0);
                    else
                        nest = nest + 8'd1;
                end
                else if (b == CH_I)
                    scan_mode = MODE_INT;
                else if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    skip_len  = digit;
                    scan_mode = MODE_LEN;
                end
                else if (b == CH_E)
                begin
                    if (nest == 8'd0)
                        close_scan(ST_ILLEGAL, 64'd0, 64'd0);
                    else
                    begin
                        nest = nest - 8'd1;
                        if (nest == 8'd0)
                            close_scan(ST_FOUND, val_start, byte_off);
                    end
                end
                else
                    close_scan(ST_ILLEGAL, 64'd0, 64'd0);
            end
            MODE_INT:
            begin
                if (b == CH_E)
                    scan_mode = MODE_SCAN;
            end
            MODE_LEN:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    if (skip_len > (OFF_MASK - digit) / 64'd10)
                        close_scan(ST_OVER, 64'd0, 64'd0);
                    else
                        skip_len = skip_len * 64'd10 + digit;
                end
                else
                    scan_mode = (skip_len == 64'd0) ? MODE_SCAN : MODE_SKIP;
            end
            MODE_SKIP:
            begin
                if (skip_len != 64'd0)
                    skip_len = skip_len - 64'd1;
                if (skip_len == 64'd0)
                    scan_mode = MODE_SCAN;
            end
            default:
            begin
            end
        endcase
        byte_off = (byte_off + 64'd1) & OFF_MASK;
        if (last)
        begin
            if (!span_ready && scan_mode != MODE_DONE)
                close_scan((scan_mode == MODE_HUNT) ? ST_NOKEY : ST_TRUNC, 64'd0, 64'd0);
            clear_scan();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        err_cnt++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : watch
        span_rec_t seen;
        span_rec_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                scan_byte(s_axis_tdata, s_axis_tlast);
                if (span_ready)
                    span_q = {span_q, use_typed ? typed_span : span_out};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = '{status_t'(m_axis_tdata[2:0]), m_axis_tdata[34:3], m_axis_tdata[66:35]};
                if (seen.status == ST_FOUND)
                    found_seen++;
                else
                    fail_seen++;
                if (span_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: result beat with nothing expected, actual status %0d",
                             $time, seen.status);
                end
                else
                begin
                    want = span_q.pop_front();
                    if (seen.status != want.status)
                        flag_mismatch("status", 32'(want.status), 32'(seen.status));
                    if (seen.start_off != want.start_off)
                        flag_mismatch("span_start", want.start_off, seen.start_off);
                    if (seen.end_off != want.end_off)
                        flag_mismatch("span_end", want.end_off, seen.end_off);
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_beat(file_q[i], i == file_q.size() - 1);
        files_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            file_q = {file_q, s[i]};
    endtask

    task automatic add_random(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom_range(255));
            file_q = {file_q, b};
        end
    endtask

    task automatic add_digit(input int lo);
        logic [7:0] b;
        b = CH_ZERO + 8'($urandom_range(9, lo));
        file_q = {file_q, b};
    endtask

    // integer or string token with random content
    task automatic add_scalar();
        int n;
        logic [7:0] b;
        if ($urandom_range(1) == 1)
        begin
            file_q = {file_q, CH_I};
            if ($urandom_range(2) == 0)
                file_q = {file_q, CH_MINUS};
            repeat ($urandom_range(4, 1))
                add_digit(0);
            if ($urandom_range(4) == 0)
            begin
                b = 8'($urandom_range(255));
                if (b != CH_E)
                    file_q = {file_q, b};
            end
            file_q = {file_q, CH_E};
        end
        else
        begin
            if ($urandom_range(9) == 0)
                n = $urandom_range(40, 10);
            else
                n = $urandom_range(9);
            add_text($sformatf("%0d", n));
            if ($urandom_range(99) < 85)
                file_q = {file_q, CH_COLON};
            else
                add_random(1);
            add_random(n);
        end
    endtask

    // value, not always well-formed: an optional scalar at depth zero, then a closed container
    task automatic add_value();
        int lvl;
        int count;
        int r;
        lvl = 1;
        count = 0;
        if ($urandom_range(3) == 0)
            add_scalar();
        file_q = {file_q, ($urandom_range(1) == 1) ? CH_D : CH_L};
        while (lvl > 0)
        begin
            r = $urandom_range(99);
            if (count > 12 || r < 30)
            begin
                file_q = {file_q, CH_E};
                lvl--;
            end
            else if (r < 50 && lvl < 4)
            begin
                file_q = {file_q, ($urandom_range(1) == 1) ? CH_D : CH_L};
                lvl++;
            end
            else
                add_scalar();
            count++;
        end
    endtask

    task automatic make_random_file();
        int kind;
        int keep;
        file_q.delete();
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            add_random($urandom_range(4));
            add_text("4:info");
            add_value();
            if ($urandom_range(5) == 0)
                add_random($urandom_range(3, 1));
            if (kind >= 68)
                file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom_range(255));
            else if (kind >= 60)
            begin
                keep = $urandom_range(file_q.size(), 1);
                while (file_q.size() > keep)
                    void'(file_q.pop_back());
            end
        end
        else if (kind < 85)
        begin
            // noise with key fragments
            repeat ($urandom_range(12, 1))
            begin
                if ($urandom_range(3) == 0)
                    add_text("4:in");
                else
                    add_random(1);
            end
        end
        else if (kind < 93)
        begin
            // long lengths around the overflow point
            add_text("4:infod");
            add_digit(1);
            repeat ($urandom_range(11, 8))
                add_digit(0);
            if ($urandom_range(1) == 1)
            begin
                file_q = {file_q, CH_COLON};
                add_random($urandom_range(3));
            end
        end
        else
        begin
            add_text("4:info");
            if ($urandom_range(1) == 1)
                file_q = {file_q, CH_E};
            add_random($urandom_range(3, 1));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        use_typed     = 1'b0;
        typed_span    = '0;
        span_ready    = 1'b0;
        span_out      = '0;
        clear_scan();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            use_typed  = dir_typed[r];
            typed_span = dir_exp[r];
            file_q.delete();
            add_text(dir_text[r]);
            send_file();
        end
        use_typed = 1'b0;

        for (int phase = 0; phase < 4; phase++)
        begin
            // hold the sender until every span is back
            while (span_q.size() != 0)
                @(negedge clk);
            idle_pct  = (phase == 1) ? 45 : (phase == 3) ? 19 : 0;
            stall_pct = (phase == 2) ? 45 : (phase == 3) ? 19 : 0;
            if (phase == 1 || phase == 3)
            begin
                // nesting at the depth limit: one past it, then exactly at it
                file_q.delete();
                add_text("4:info");
                repeat (DEPTH_MAX_DEF + (phase == 1 ? 1 : 0))
                    file_q = {file_q, CH_D};
                file_q = {file_q, CH_E};
                send_file();
            end
            begin : random_part
                int budget;
                budget = bytes_sent + PHASE_BYTES;
                while (bytes_sent < budget)
                begin
                    make_random_file();
                    send_file();
                end
            end
        end

        while (span_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("scanned %0d files, %0d bytes, across four sender and receiver pacing phases",
                 files_sent, bytes_sent);
        $display("spans back: %0d found, %0d with an error status", found_seen, fail_seen);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- bencode_info_dict_extent_finder_core.f -----
rtl/core/bidef_pkg.sv
rtl/core/bidef_scanner.sv
rtl/core/bencode_info_dict_extent_finder_core.sv
bench/tb_bencode_info_dict_extent_finder_core.sv
